FILE: hdl/ptts_pkg.sv
package ptts_pkg;

    // Width and ceiling of the saturating event counters.
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Request opcodes.
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_LOAD    = 2'd1,
        OP_RESTART = 2'd2,
        OP_STATS   = 2'd3
    } op_t;

    // Configuration register byte addresses.
    localparam logic [2:0] REG_ADDR_COUNT  = 3'd0;
    localparam logic [2:0] REG_ADDR_POLICY = 3'd4;

    // Per-cell control strobes from the sequencer.
    typedef struct packed {
        logic tick;
        logic enable;
        logic load;
        logic restart;
        logic run;
    } cell_ctrl_t;

    // Saturating add of a small increment to a counter.
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                                 input logic [1:0] d);
        logic [CNT_W:0] s;
        s = {1'b0, v} + (CNT_W+1)'(d);
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

FILE: hdl/ptts_cell.sv
module ptts_cell
    import ptts_pkg::*;
#(
    parameter int TIME_WIDTH = 32,
    parameter int IDX_W      = 3,
    parameter int SUM_W      = 5,
    parameter int CELL_IDX   = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctrl_t            ctrl,
    input  logic                  policy,
    input  logic [TIME_WIDTH-1:0] now_time,
    input  logic [15:0]           ld_period,
    input  logic [15:0]           ld_exec,
    input  logic [15:0]           ld_deadline,
    input  logic                  in_found,
    input  logic [TIME_WIDTH-1:0] in_key,
    input  logic [IDX_W-1:0]      in_pick,
    input  logic                  in_last,
    input  logic [SUM_W-1:0]      in_sum,
    output logic                  out_found,
    output logic [TIME_WIDTH-1:0] out_key,
    output logic [IDX_W-1:0]      out_pick,
    output logic                  out_last,
    output logic [SUM_W-1:0]      out_sum,
    output logic                  released_flag,
    output logic                  missed_flag,
    output logic [CNT_W-1:0]      released_count,
    output logic [CNT_W-1:0]      completed_count,
    output logic [CNT_W-1:0]      missed_count
);

    logic [15:0]           period_reg;
    logic [15:0]           exec_reg;
    logic [15:0]           deadline_reg;
    logic [TIME_WIDTH-1:0] release_reg;
    logic [TIME_WIDTH-1:0] abs_dl_reg;
    logic [15:0]           remaining_reg;
    logic                  active_reg;
    logic                  marked_reg;
    logic [CNT_W-1:0]      rel_cnt_reg;
    logic [CNT_W-1:0]      cmp_cnt_reg;
    logic [CNT_W-1:0]      mis_cnt_reg;
    logic                  rel_flag_reg;
    logic                  mis_flag_reg;
    logic [1:0]            miss_num_reg;
    logic                  tok_found_reg;
    logic [TIME_WIDTH-1:0] tok_key_reg;
    logic [IDX_W-1:0]      tok_pick_reg;
    logic                  tok_last_reg;
    logic [SUM_W-1:0]      tok_sum_reg;

    logic                  due;
    logic                  miss_rel;
    logic                  act1;
    logic [15:0]           rem1;
    logic                  marked1;
    logic [TIME_WIDTH-1:0] abs1;
    logic                  miss_dl;
    logic [1:0]            miss_num;
    logic                  eligible;
    logic [TIME_WIDTH-1:0] key;
    logic                  take;

    // Release and deadline checks for one tick.
    always_comb
    begin
        due      = now_time >= release_reg;
        miss_rel = due && active_reg && (remaining_reg != '0) && !marked_reg;
        act1     = due ? 1'b1 : active_reg;
        rem1     = due ? exec_reg : remaining_reg;
        marked1  = due ? 1'b0 : marked_reg;
        abs1     = due ? TIME_WIDTH'(now_time + TIME_WIDTH'(deadline_reg)) : abs_dl_reg;
        miss_dl  = act1 && (rem1 != '0) && (now_time >= abs1) && !marked1;
        miss_num = 2'(miss_rel) + 2'(miss_dl);
    end

    // Task parameters, written by a load request.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            period_reg   <= ld_period;
            exec_reg     <= ld_exec;
            deadline_reg <= ld_deadline;
        end
    end

    // Runtime state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            release_reg   <= '0;
            abs_dl_reg    <= '0;
            remaining_reg <= '0;
            active_reg    <= 1'b0;
            marked_reg    <= 1'b0;
            rel_cnt_reg   <= '0;
            cmp_cnt_reg   <= '0;
            mis_cnt_reg   <= '0;
            rel_flag_reg  <= 1'b0;
            mis_flag_reg  <= 1'b0;
            miss_num_reg  <= '0;
        end
        else if (ctrl.load || ctrl.restart)
        begin
            release_reg   <= '0;
            abs_dl_reg    <= ctrl.load ? TIME_WIDTH'(ld_deadline) : TIME_WIDTH'(deadline_reg);
            remaining_reg <= '0;
            active_reg    <= 1'b0;
            marked_reg    <= 1'b0;
            rel_cnt_reg   <= '0;
            cmp_cnt_reg   <= '0;
            mis_cnt_reg   <= '0;
        end
        else if (ctrl.tick)
        begin
            if (ctrl.enable)
            begin
                if (due)
                begin
                    release_reg <= TIME_WIDTH'(release_reg + TIME_WIDTH'(period_reg));
                    rel_cnt_reg <= sat_add(rel_cnt_reg, 2'd1);
                end
                abs_dl_reg    <= abs1;
                remaining_reg <= rem1;
                active_reg    <= act1;
                marked_reg    <= marked1 | miss_dl;
                mis_cnt_reg   <= sat_add(mis_cnt_reg, miss_num);
            end
            rel_flag_reg <= ctrl.enable && due;
            mis_flag_reg <= ctrl.enable && (miss_num != '0);
            miss_num_reg <= ctrl.enable ? miss_num : 2'd0;
        end
        else if (ctrl.run)
        begin
            remaining_reg <= remaining_reg - 16'd1;
            if (remaining_reg == 16'd1)
            begin
                active_reg  <= 1'b0;
                cmp_cnt_reg <= sat_add(cmp_cnt_reg, 2'd1);
            end
        end
    end

    // Selection token: keep the better of the incoming and own candidate.
    always_comb
    begin
        eligible = ctrl.enable && active_reg && (remaining_reg != '0);
        key      = policy ? abs_dl_reg : TIME_WIDTH'(period_reg);
        take     = eligible && (!in_found || (key < in_key));
    end

    always_ff @(posedge clk)
    begin
        tok_found_reg <= in_found || take;
        tok_key_reg   <= take ? key : in_key;
        tok_pick_reg  <= take ? IDX_W'(CELL_IDX) : in_pick;
        tok_last_reg  <= take ? (remaining_reg == 16'd1) : in_last;
        tok_sum_reg   <= SUM_W'(in_sum + SUM_W'(miss_num_reg));
    end

    assign out_found       = tok_found_reg;
    assign out_key         = tok_key_reg;
    assign out_pick        = tok_pick_reg;
    assign out_last        = tok_last_reg;
    assign out_sum         = tok_sum_reg;
    assign released_flag   = rel_flag_reg;
    assign missed_flag     = mis_flag_reg;
    assign released_count  = rel_cnt_reg;
    assign completed_count = cmp_cnt_reg;
    assign missed_count    = mis_cnt_reg;

endmodule

FILE: hdl/periodic_task_tick_scheduler_core.sv
// Periodic task scheduler, rate monotonic or earliest deadline first.
// Requests enter on in_valid/in_ready with an opcode: tick, load task,
// restart, or read task statistics. Every request yields exactly one
// result on out_valid/out_ready, in request order.
// Each task lives in one cell of a chain. A tick updates all cells at
// once (releases and deadline misses), then a selection token walks the
// chain one cell per cycle and a selection step loads the result
// register; load, restart and statistics requests load it directly.
// One request is in work at a time, and in_ready returns as the result
// register loads, so a request is accepted only once the last completed.
// The result register lets the next request be accepted while a result
// waits; a held result stalls only the following request's completion.
// Reset clears time, totals and all runtime state; task parameters are
// undefined until loaded. The APB port holds active_task_count at
// address 0 and policy_mode at address 4. It must be written only
// while idle; the block itself does not enforce this.
module periodic_task_tick_scheduler_core
    import ptts_pkg::*;
#(
    parameter int NUM_TASKS  = 8,
    parameter int TIME_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [2:0]  task_index,
    input  logic [15:0] period,
    input  logic [15:0] exec_ticks,
    input  logic [15:0] rel_deadline,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] tick_time,
    output logic [2:0]  run_task,
    output logic        run_valid,
    output logic        job_finished,
    output logic [7:0]  released_mask,
    output logic [7:0]  missed_mask,
    output logic        switched,
    output logic [15:0] total_misses,
    output logic [15:0] total_switches,
    output logic [15:0] stat_released,
    output logic [15:0] stat_completed,
    output logic [15:0] stat_missed,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int SUM_W = $clog2(2 * NUM_TASKS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_WRITE
    } state_t;

    state_t                state_reg;
    logic [IDX_W-1:0]      scan_cnt_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic                  last_valid_reg;
    logic [IDX_W-1:0]      last_pick_reg;
    logic [CNT_W-1:0]      miss_total_reg;
    logic [CNT_W-1:0]      switch_total_reg;
    op_t                   op_reg;
    logic [2:0]            idx_reg;
    logic [TIME_WIDTH-1:0] t_reg;
    logic [IDX_W-1:0]      res_run_reg;
    logic                  res_valid_reg;
    logic                  res_fin_reg;
    logic                  res_sw_reg;
    logic [3:0]            active_task_count_reg;
    logic                  policy_mode_reg;

    logic                  out_valid_reg;
    logic [31:0]           tick_time_reg;
    logic [2:0]            run_task_reg;
    logic                  run_valid_reg;
    logic                  job_finished_reg;
    logic [7:0]            released_mask_reg;
    logic [7:0]            missed_mask_reg;
    logic                  switched_reg;
    logic [15:0]           total_misses_reg;
    logic [15:0]           total_switches_reg;
    logic [15:0]           stat_released_reg;
    logic [15:0]           stat_completed_reg;
    logic [15:0]           stat_missed_reg;

    logic                  accept;
    logic                  cfg_write;
    logic                  out_free;
    logic [CNT_W:0]        miss_sum;
    logic                  stat_ok;
    logic [IDX_W-1:0]      stat_idx;
    logic [7:0]            rel_mask;
    logic [7:0]            mis_mask;

    cell_ctrl_t            ctrl [NUM_TASKS];
    logic                  tok_found [NUM_TASKS+1];
    logic [TIME_WIDTH-1:0] tok_key [NUM_TASKS+1];
    logic [IDX_W-1:0]      tok_pick [NUM_TASKS+1];
    logic                  tok_last [NUM_TASKS+1];
    logic [SUM_W-1:0]      tok_sum [NUM_TASKS+1];
    logic                  cell_rel [NUM_TASKS];
    logic                  cell_mis [NUM_TASKS];
    logic [CNT_W-1:0]      cnt_rel [NUM_TASKS];
    logic [CNT_W-1:0]      cnt_cmp [NUM_TASKS];
    logic [CNT_W-1:0]      cnt_mis [NUM_TASKS];
    logic [15:0]           ld_deadline;

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign ld_deadline = (rel_deadline == 16'd0) ? period : rel_deadline;

    // Empty token enters the head of the chain.
    assign tok_found[0] = 1'b0;
    assign tok_key[0]   = '0;
    assign tok_pick[0]  = '0;
    assign tok_last[0]  = 1'b0;
    assign tok_sum[0]   = '0;

    // Row of task cells.
    for (genvar i = 0; i < NUM_TASKS; i++)
    begin : g_cell
        always_comb
        begin
            ctrl[i].tick    = accept && (op_t'(opcode) == OP_TICK);
            ctrl[i].enable  = 32'(active_task_count_reg) > i;
            ctrl[i].load    = accept && (op_t'(opcode) == OP_LOAD) && (32'(task_index) == i);
            ctrl[i].restart = accept && (op_t'(opcode) == OP_RESTART);
            ctrl[i].run     = (state_reg == S_FINISH) && tok_found[NUM_TASKS]
                              && (tok_pick[NUM_TASKS] == IDX_W'(i));
        end

        ptts_cell #(
            .TIME_WIDTH (TIME_WIDTH),
            .IDX_W      (IDX_W),
            .SUM_W      (SUM_W),
            .CELL_IDX   (i)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .ctrl            (ctrl[i]),
            .policy          (policy_mode_reg),
            .now_time        (now_reg),
            .ld_period       (period),
            .ld_exec         (exec_ticks),
            .ld_deadline     (ld_deadline),
            .in_found        (tok_found[i]),
            .in_key          (tok_key[i]),
            .in_pick         (tok_pick[i]),
            .in_last         (tok_last[i]),
            .in_sum          (tok_sum[i]),
            .out_found       (tok_found[i+1]),
            .out_key         (tok_key[i+1]),
            .out_pick        (tok_pick[i+1]),
            .out_last        (tok_last[i+1]),
            .out_sum         (tok_sum[i+1]),
            .released_flag   (cell_rel[i]),
            .missed_flag     (cell_mis[i]),
            .released_count  (cnt_rel[i]),
            .completed_count (cnt_cmp[i]),
            .missed_count    (cnt_mis[i])
        );
    end

    // Event masks cover the first eight tasks only.
    for (genvar b = 0; b < 8; b++)
    begin : g_mask
        if (b < NUM_TASKS)
        begin : g_on
            assign rel_mask[b] = cell_rel[b];
            assign mis_mask[b] = cell_mis[b];
        end
        else
        begin : g_off
            assign rel_mask[b] = 1'b0;
            assign mis_mask[b] = 1'b0;
        end
    end

    assign miss_sum = {1'b0, miss_total_reg} + (CNT_W+1)'(tok_sum[NUM_TASKS]);
    assign stat_ok  = 32'(idx_reg) < NUM_TASKS;
    assign stat_idx = IDX_W'(idx_reg);

    // Configuration port.
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_task_count_reg <= '0;
            policy_mode_reg       <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr)
                REG_ADDR_COUNT:  active_task_count_reg <= pwdata[3:0];
                REG_ADDR_POLICY: policy_mode_reg       <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_ADDR_COUNT:  prdata = {28'd0, active_task_count_reg};
            REG_ADDR_POLICY: prdata = {31'd0, policy_mode_reg};
            default:         prdata = '0;
        endcase
    end

    // Sequencer, scheduler totals and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            scan_cnt_reg     <= '0;
            now_reg          <= '0;
            last_valid_reg   <= 1'b0;
            last_pick_reg    <= '0;
            miss_total_reg   <= '0;
            switch_total_reg <= '0;
            op_reg           <= OP_TICK;
            idx_reg          <= '0;
            t_reg            <= '0;
            res_run_reg      <= '0;
            res_valid_reg    <= 1'b0;
            res_fin_reg      <= 1'b0;
            res_sw_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg        <= op_t'(opcode);
                        idx_reg       <= task_index;
                        t_reg         <= now_reg;
                        res_run_reg   <= '0;
                        res_valid_reg <= 1'b0;
                        res_fin_reg   <= 1'b0;
                        res_sw_reg    <= 1'b0;
                        scan_cnt_reg  <= '0;
                        if (op_t'(opcode) == OP_RESTART)
                        begin
                            now_reg          <= '0;
                            t_reg            <= '0;
                            last_valid_reg   <= 1'b0;
                            last_pick_reg    <= '0;
                            miss_total_reg   <= '0;
                            switch_total_reg <= '0;
                        end
                        state_reg <= (op_t'(opcode) == OP_TICK) ? S_SCAN : S_WRITE;
                    end
                end
                S_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    if (scan_cnt_reg == IDX_W'(NUM_TASKS - 1))
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    miss_total_reg <= miss_sum[CNT_W] ? CNT_MAX : miss_sum[CNT_W-1:0];
                    now_reg        <= now_reg + 1'b1;
                    if (tok_found[NUM_TASKS])
                    begin
                        res_run_reg    <= tok_pick[NUM_TASKS];
                        res_valid_reg  <= 1'b1;
                        res_fin_reg    <= tok_last[NUM_TASKS];
                        last_valid_reg <= 1'b1;
                        last_pick_reg  <= tok_pick[NUM_TASKS];
                        if (last_valid_reg && (last_pick_reg != tok_pick[NUM_TASKS]))
                        begin
                            res_sw_reg       <= 1'b1;
                            switch_total_reg <= sat_add(switch_total_reg, 2'd1);
                        end
                    end
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if ((state_reg == S_WRITE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded as the request completes.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_WRITE) && out_free)
        begin
            tick_time_reg      <= 32'(t_reg);
            run_task_reg       <= 3'(res_run_reg);
            run_valid_reg      <= res_valid_reg;
            job_finished_reg   <= res_fin_reg;
            switched_reg       <= res_sw_reg;
            total_misses_reg   <= miss_total_reg;
            total_switches_reg <= switch_total_reg;
            released_mask_reg  <= (op_reg == OP_TICK) ? rel_mask : 8'd0;
            missed_mask_reg    <= (op_reg == OP_TICK) ? mis_mask : 8'd0;
            if ((op_reg == OP_STATS) && stat_ok)
            begin
                stat_released_reg  <= cnt_rel[stat_idx];
                stat_completed_reg <= cnt_cmp[stat_idx];
                stat_missed_reg    <= cnt_mis[stat_idx];
            end
            else
            begin
                stat_released_reg  <= '0;
                stat_completed_reg <= '0;
                stat_missed_reg    <= '0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign tick_time      = tick_time_reg;
    assign run_task       = run_task_reg;
    assign run_valid      = run_valid_reg;
    assign job_finished   = job_finished_reg;
    assign released_mask  = released_mask_reg;
    assign missed_mask    = missed_mask_reg;
    assign switched       = switched_reg;
    assign total_misses   = total_misses_reg;
    assign total_switches = total_switches_reg;
    assign stat_released  = stat_released_reg;
    assign stat_completed = stat_completed_reg;
    assign stat_missed    = stat_missed_reg;

`ifndef SYNTHESIS
    // A switch is only reported for a tick in which a task ran.
    a_switch_runs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!switched || run_valid))
        else $error("switch reported without a running task");

    // A finished job is only reported for a tick in which a task ran.
    a_finish_runs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!job_finished || run_valid))
        else $error("job finish reported without a running task");

    // A restart request clears the time base.
    a_restart_time: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op_t'(opcode) == OP_RESTART)) |=> (now_reg == '0))
        else $error("time not cleared by restart");

    // The selection step is followed in the next cycle by the result state.
    a_finish_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |=> (state_reg == S_WRITE))
        else $error("selection step did not hand off to the result");
`endif

endmodule

FILE: verif/periodic_task_tick_scheduler_core_test.sv
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_core_test;
    import ptts_pkg::*;

    localparam int NTASK = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1300;

    // One scheduler result, field for field.
    typedef struct packed {
        logic [31:0] tick_time;
        logic [2:0]  run_task;
        logic        run_valid;
        logic        job_finished;
        logic [7:0]  released_mask;
        logic [7:0]  missed_mask;
        logic        switched;
        logic [15:0] total_misses;
        logic [15:0] total_switches;
        logic [15:0] stat_released;
        logic [15:0] stat_completed;
        logic [15:0] stat_missed;
    } sched_result_t;

    // One request as driven on the input channel.
    typedef struct packed {
        op_t         op;
        logic [2:0]  idx;
        logic [15:0] per;
        logic [15:0] ex;
        logic [15:0] dl;
    } sched_req_t;

    // A directed row: the request, and a literal result where it is obvious.
    typedef struct packed {
        sched_req_t    req;
        logic          has_literal;
        sched_result_t literal;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0]  opcode = '0;
    logic [2:0]  task_index = '0;
    logic [15:0] period = '0;
    logic [15:0] exec_ticks = '0;
    logic [15:0] rel_deadline = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [31:0] tick_time;
    logic [2:0]  run_task;
    logic run_valid, job_finished, switched;
    logic [7:0]  released_mask, missed_mask;
    logic [15:0] total_misses, total_switches;
    logic [15:0] stat_released, stat_completed, stat_missed;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    periodic_task_tick_scheduler_core u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .task_index(task_index), .period(period),
        .exec_ticks(exec_ticks), .rel_deadline(rel_deadline),
        .out_valid(out_valid), .out_ready(out_ready),
        .tick_time(tick_time), .run_task(run_task), .run_valid(run_valid),
        .job_finished(job_finished), .released_mask(released_mask),
        .missed_mask(missed_mask), .switched(switched),
        .total_misses(total_misses), .total_switches(total_switches),
        .stat_released(stat_released), .stat_completed(stat_completed),
        .stat_missed(stat_missed),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // Shadow scheduler state.
    logic [31:0] sh_now;
    logic [2:0]  sh_last;
    logic        sh_last_valid;
    logic [15:0] sh_period [NTASK];
    logic [15:0] sh_exec [NTASK];
    logic [15:0] sh_dl [NTASK];
    logic [31:0] sh_next_rel [NTASK];
    logic [31:0] sh_abs_dl [NTASK];
    logic [15:0] sh_remain [NTASK];
    logic        sh_active [NTASK];
    logic        sh_marked [NTASK];
    logic [15:0] sh_rel_cnt [NTASK];
    logic [15:0] sh_done_cnt [NTASK];
    logic [15:0] sh_miss_cnt [NTASK];
    logic [15:0] sh_miss_total;
    logic [15:0] sh_switch_total;
    logic [3:0]  cfg_count;
    logic        cfg_edf;
    bit          loaded [NTASK];

    sched_result_t pending_results[$];
    logic          pending_literal[$];
    sched_result_t pending_literal_val[$];

    int error_count = 0;
    int cycle_count = 0;
    int accepted_count = 0;
    int result_count = 0;
    int tick_count = 0;
    bit drain_mode = 1'b0;
    bit hold_off = 1'b0;

    function automatic logic [15:0] sat_inc16(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic void clear_task(int i);
        sh_next_rel[i] = '0;
        sh_abs_dl[i] = {16'd0, sh_dl[i]};
        sh_remain[i] = '0;
        sh_active[i] = 1'b0;
        sh_marked[i] = 1'b0;
        sh_rel_cnt[i] = '0;
        sh_done_cnt[i] = '0;
        sh_miss_cnt[i] = '0;
    endfunction

    function automatic void restart_schedule();
        sh_now = '0;
        sh_last = '0;
        sh_last_valid = 1'b0;
        sh_miss_total = '0;
        sh_switch_total = '0;
        for (int i = 0; i < NTASK; i++)
            clear_task(i);
    endfunction

    function automatic void flag_miss(int i, ref logic [7:0] mask);
        sh_miss_cnt[i] = sat_inc16(sh_miss_cnt[i]);
        sh_miss_total = sat_inc16(sh_miss_total);
        sh_marked[i] = 1'b1;
        mask[i] = 1'b1;
    endfunction

    // Advance the shadow scheduler by one request and return its result.
    function automatic sched_result_t schedule_step(sched_req_t r);
        sched_result_t res;
        int n;
        bit found;
        logic [31:0] best, key;
        int pick;
        logic [7:0] mask;
        res = '0;
        res.tick_time = sh_now;
        case (r.op)
            OP_TICK:
            begin
                n = (cfg_count > NTASK) ? NTASK : cfg_count;
                mask = '0;
                for (int i = 0; i < n; i++)
                begin
                    if (sh_now >= sh_next_rel[i])
                    begin
                        if (sh_active[i] && sh_remain[i] != 0 && !sh_marked[i])
                            flag_miss(i, mask);
                        sh_active[i] = 1'b1;
                        sh_remain[i] = sh_exec[i];
                        sh_rel_cnt[i] = sat_inc16(sh_rel_cnt[i]);
                        sh_next_rel[i] = sh_next_rel[i] + sh_period[i];
                        sh_abs_dl[i] = sh_now + sh_dl[i];
                        sh_marked[i] = 1'b0;
                        res.released_mask[i] = 1'b1;
                    end
                end
                for (int i = 0; i < n; i++)
                begin
                    if (sh_active[i] && sh_remain[i] != 0 && sh_now >= sh_abs_dl[i]
                        && !sh_marked[i])
                        flag_miss(i, mask);
                end
                res.missed_mask = mask;
                found = 1'b0;
                best = '0;
                pick = 0;
                for (int i = 0; i < n; i++)
                begin
                    if (!(sh_active[i] && sh_remain[i] != 0))
                        continue;
                    key = cfg_edf ? sh_abs_dl[i] : {16'd0, sh_period[i]};
                    if (!found || key < best)
                    begin
                        found = 1'b1;
                        best = key;
                        pick = i;
                    end
                end
                if (found)
                begin
                    if (sh_last_valid && sh_last != 3'(pick))
                    begin
                        res.switched = 1'b1;
                        sh_switch_total = sat_inc16(sh_switch_total);
                    end
                    sh_last_valid = 1'b1;
                    sh_last = 3'(pick);
                    res.run_valid = 1'b1;
                    res.run_task = 3'(pick);
                    sh_remain[pick] = sh_remain[pick] - 16'd1;
                    if (sh_remain[pick] == 0)
                    begin
                        sh_active[pick] = 1'b0;
                        sh_done_cnt[pick] = sat_inc16(sh_done_cnt[pick]);
                        res.job_finished = 1'b1;
                    end
                end
                sh_now = sh_now + 32'd1;
            end
            OP_LOAD:
            begin
                sh_period[r.idx] = r.per;
                sh_exec[r.idx] = r.ex;
                sh_dl[r.idx] = (r.dl == 0) ? r.per : r.dl;
                clear_task(r.idx);
                loaded[r.idx] = 1'b1;
            end
            OP_RESTART:
            begin
                restart_schedule();
                res.tick_time = sh_now;
            end
            default:
            begin
                res.stat_released = sh_rel_cnt[r.idx];
                res.stat_completed = sh_done_cnt[r.idx];
                res.stat_missed = sh_miss_cnt[r.idx];
            end
        endcase
        res.total_misses = sh_miss_total;
        res.total_switches = sh_switch_total;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("MISMATCH result %0d %s: got %0h expected %0h", result_count, what, got, want);
    endtask

    // Result checker: compares each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        sched_result_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{tick_time, run_task, run_valid, job_finished, released_mask,
                    missed_mask, switched, total_misses, total_switches,
                    stat_released, stat_completed, stat_missed};
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 32'd0, 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (pending_literal.pop_front())
                begin
                    if (pending_literal_val.pop_front() != want)
                        report_mismatch("directed table vs predictor", 0, 0);
                end
                else
                    void'(pending_literal_val.pop_front());
                if (got.tick_time != want.tick_time)
                    report_mismatch("tick_time", got.tick_time, want.tick_time);
                if (got.run_task != want.run_task)
                    report_mismatch("run_task", got.run_task, want.run_task);
                if (got.run_valid != want.run_valid)
                    report_mismatch("run_valid", got.run_valid, want.run_valid);
                if (got.job_finished != want.job_finished)
                    report_mismatch("job_finished", got.job_finished, want.job_finished);
                if (got.released_mask != want.released_mask)
                    report_mismatch("released_mask", got.released_mask, want.released_mask);
                if (got.missed_mask != want.missed_mask)
                    report_mismatch("missed_mask", got.missed_mask, want.missed_mask);
                if (got.switched != want.switched)
                    report_mismatch("switched", got.switched, want.switched);
                if (got.total_misses != want.total_misses)
                    report_mismatch("total_misses", got.total_misses, want.total_misses);
                if (got.total_switches != want.total_switches)
                    report_mismatch("total_switches", got.total_switches,
                                    want.total_switches);
                if (got.stat_released != want.stat_released)
                    report_mismatch("stat_released", got.stat_released, want.stat_released);
                if (got.stat_completed != want.stat_completed)
                    report_mismatch("stat_completed", got.stat_completed,
                                    want.stat_completed);
                if (got.stat_missed != want.stat_missed)
                    report_mismatch("stat_missed", got.stat_missed, want.stat_missed);
            end
            result_count++;
        end
    end

    // Receiver: random stall bursts, a long hold-off on request, none at the end.
    always @(posedge clk)
    begin
        int gap;
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off)
            out_ready <= 1'b0;
        else if (!drain_mode && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap - 1) @(posedge clk);
        end
        else
            out_ready <= 1'b1;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("periodic_task_tick_scheduler_core_test: errors");
            $finish;
        end
    end

    // Setup phase and access phase, then an idle gap before the next transfer.
    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Program both registers; the shadow copy follows.
    task automatic set_config(logic [3:0] count, logic edf);
        apb_write(REG_ADDR_COUNT, {28'd0, count});
        apb_write(REG_ADDR_POLICY, {31'd0, edf});
        cfg_count = count;
        cfg_edf = edf;
    endtask

    // Offer one request and hold it until accepted; predict on acceptance.
    task automatic send_request(sched_req_t r, logic has_lit, sched_result_t lit, bit gaps);
        int gap;
        if (gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= r.op;
        task_index <= r.idx;
        period <= r.per;
        exec_ticks <= r.ex;
        rel_deadline <= r.dl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(schedule_step(r));
        pending_literal.push_back(has_lit);
        pending_literal_val.push_back(lit);
        accepted_count++;
        if (r.op == OP_TICK)
            tick_count++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (NTASK + 8) @(posedge clk);
    endtask

    // Random request: mostly ticks over loaded tasks, some loads, restarts and reads.
    function automatic sched_req_t random_request();
        sched_req_t r;
        int pick;
        r.idx = 3'($urandom_range(0, 7));
        r.per = 16'($urandom);
        r.ex = 16'($urandom);
        r.dl = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70)
            r.op = OP_TICK;
        else if (pick < 82)
        begin
            r.op = OP_LOAD;
            // Mostly short periods so jobs release and finish often.
            if ($urandom_range(0, 9) != 0)
            begin
                r.per = 16'($urandom_range(0, 12));
                r.ex = 16'($urandom_range(0, 5));
                r.dl = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 14));
            end
        end
        else if (pick < 84)
            r.op = OP_RESTART;
        else
            r.op = OP_STATS;
        return r;
    endfunction

    // Directed table.
    directed_row_t directed_rows[$];

    function automatic directed_row_t row(op_t op, logic [2:0] idx, logic [15:0] per,
                                          logic [15:0] ex, logic [15:0] dl);
        directed_row_t d;
        d = '0;
        d.req = '{op, idx, per, ex, dl};
        return d;
    endfunction

    initial
    begin
        directed_row_t d;
        sched_req_t r;
        int phase_count;
        sched_result_t z;
        for (int i = 0; i < NTASK; i++)
        begin
            sh_period[i] = '0;
            sh_exec[i] = '0;
            sh_dl[i] = '0;
            loaded[i] = 1'b0;
        end
        cfg_count = '0;
        cfg_edf = 1'b0;
        restart_schedule();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty tick, stats and restart after reset have obvious results.
        z = '0;
        d = row(OP_TICK, 0, 0, 0, 0);
        d.has_literal = 1'b1;
        d.literal = z;
        directed_rows.push_back(d);
        d = row(OP_STATS, 7, 0, 0, 0);
        d.has_literal = 1'b1;
        d.literal = z;
        d.literal.tick_time = 32'd1;
        directed_rows.push_back(d);
        d = row(OP_RESTART, 3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        d.has_literal = 1'b1;
        d.literal = z;
        directed_rows.push_back(d);
        // Extremes, zero exec, zero period, zero deadline.
        directed_rows.push_back(row(OP_LOAD, 0, 16'd4, 16'd2, 16'd0));
        directed_rows.push_back(row(OP_LOAD, 1, 16'd0, 16'd1, 16'd3));
        directed_rows.push_back(row(OP_LOAD, 2, 16'd3, 16'd0, 16'd2));
        directed_rows.push_back(row(OP_LOAD, 3, 16'd2, 16'd5, 16'd1));
        directed_rows.push_back(row(OP_LOAD, 4, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        directed_rows.push_back(row(OP_LOAD, 5, 16'd1, 16'd1, 16'hFFFF));
        directed_rows.push_back(row(OP_LOAD, 6, 16'd6, 16'd3, 16'd0));
        directed_rows.push_back(row(OP_LOAD, 7, 16'd8, 16'd2, 16'd7));
        for (int k = 0; k < 10; k++)
            directed_rows.push_back(row(OP_TICK, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_STATS, 3, 0, 0, 0));
        directed_rows.push_back(row(OP_STATS, 1, 0, 0, 0));

        // The first rows run with no task scheduled; the rest with all eight.
        set_config(4'd0, 1'b0);
        foreach (directed_rows[k])
        begin
            if (k == 3)
            begin
                wait_idle();
                set_config(4'd8, 1'b0);
            end
            send_request(directed_rows[k].req, directed_rows[k].has_literal,
                         directed_rows[k].literal, 1'b1);
        end
        wait_idle();

        // Random phases across register settings, extremes included.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_config(4'd8, 1'b1);
                1: set_config(4'd15, 1'b0);
                2: set_config(4'd0, 1'b1);
                3: set_config(4'd1, 1'b0);
                default: set_config(4'($urandom_range(2, 9)), 1'($urandom_range(0, 1)));
            endcase
            // Make sure every scheduled entry has parameters before ticking.
            for (int i = 0; i < NTASK; i++)
                if (!loaded[i])
                begin
                    r = '{OP_LOAD, 3'(i), 16'($urandom_range(1, 10)),
                          16'($urandom_range(1, 4)), 16'd0};
                    send_request(r, 1'b0, z, 1'b1);
                end
            if (ph == 2)
            begin
                // Long receiver hold-off while requests keep coming.
                hold_off = 1'b1;
                fork
                    begin
                        repeat (300) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            phase_count = RANDOM_ITEMS / 8;
            drain_mode = (ph == 7);
            for (int k = 0; k < phase_count; k++)
                send_request(random_request(), 1'b0, z, !drain_mode);
            wait_idle();
        end

        $display("Covered %0d requests, %0d ticks, %0d results, RMS and EDF, counts 0..15.",
                 accepted_count, tick_count, result_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("periodic_task_tick_scheduler_core_test: clean");
        else
            $display("periodic_task_tick_scheduler_core_test: errors");
        $finish;
    end

endmodule
